### rtl/core/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants of the 3x3 RGB box blur
// Pixel and row-pair layouts, per-step control and sum records, register
// codes, and the reciprocal table of the rounding divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bb3_pkg;

  localparam int MAX_WIDTH_DEF    = 2048;
  localparam int MAX_HEIGHT_DEF   = 4096;

  localparam int CH_W             = 8;
  localparam int FW_W             = 12;
  localparam int FH_W             = 13;
  localparam int CFG_DATA_W       = 13;
  localparam int CFG_INDEX_W      = 1;
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;

  localparam int SUM_W            = 12;
  localparam int CNT_W            = 4;
  localparam int DIV_X_W          = 13;
  localparam int RECIP_W          = 18;
  localparam int RECIP_SHIFT      = 18;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    pixel_t upper;
    pixel_t lower;
  } row_pair_t;

  typedef struct packed {
    logic produce;
    logic use_top;
    logic use_bot;
    logic use_left;
    logic use_right;
    logic last;
  } adv_ctl_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
    logic [CNT_W-1:0] count;
    logic             last;
  } sum_t;

  // ceil(2^RECIP_SHIFT / (2*count)); exact floor for dividends below 2^DIV_X_W
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
    logic [RECIP_W-1:0] m;
    case (count)
      4'd1:    m = 18'd131072;
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd6:    m = 18'd21846;
      4'd9:    m = 18'd14564;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

### rtl/core/bb3_if.sv
// ----------------------------------------------------------------------------
// bb3_if: pixel stream channels of the 3x3 RGB box blur
// Valid/ready channels for input words (pixel or flush) and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bb3_in_if;
  import bb3_pkg::*;
  logic            valid;
  logic            ready;
  logic            flush;
  logic [CH_W-1:0] in_red;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_blue;

  modport source (output valid, output flush, output in_red, output in_green,
                  output in_blue, input ready);
  modport sink   (input valid, input flush, input in_red, input in_green,
                  input in_blue, output ready);
endinterface

interface bb3_out_if;
  import bb3_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic            last;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output last, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input last, output ready);
endinterface

`default_nettype wire

### rtl/core/bb3_ctrl.sv
// ----------------------------------------------------------------------------
// bb3_ctrl: frame geometry, raster counters and word intake
// Holds the frame size registers, tracks input and output positions, turns
// each accepted word except an in-frame flush into one pipeline step with its
// neighborhood masks, and adds the extra step needed by frames one row high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bb3_ctrl #(
  parameter int  MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int  MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF,
  localparam int AW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [bb3_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]     cfg_data,
  bb3_in_if.sink                             in_ch,
  output logic                               adv_valid,
  input  logic                               adv_ready,
  output logic [AW-1:0]                      adv_idx,
  output bb3_pkg::pixel_t                    adv_pix,
  output bb3_pkg::adv_ctl_t                  adv_ctl
);
  import bb3_pkg::*;

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int IRW   = $clog2(MAX_HEIGHT + 2);
  localparam int ORW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int RST_W = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
  localparam int RST_H = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

  logic [WW-1:0]   w_r, w_nxt, w_wr;
  logic [HW-1:0]   h_r, h_nxt, h_wr;
  logic [AW-1:0]   ic_r, ic_nxt;
  logic [IRW-1:0]  ir_r, ir_nxt;
  logic [AW-1:0]   oc_r, oc_nxt;
  logic [ORW-1:0]  orow_r, orow_nxt;
  logic            pending_r, pending_nxt;

  logic [FW_W-1:0] fw;
  logic [FH_W-1:0] fh;
  logic            in_frame;
  logic            adv_fire;
  logic            col_wrap;
  logic            produce;
  logic            oc_end;
  logic            or_end;

  assign fw   = cfg_data[FW_W-1:0];
  assign fh   = cfg_data[FH_W-1:0];
  assign w_wr = (fw == '0) ? WW'(1) :
                (32'(fw) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(fw);
  assign h_wr = (fh == '0) ? HW'(1) :
                (32'(fh) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(fh);

  assign in_frame    = 32'(ir_r) < 32'(h_r);
  assign in_ch.ready = !pending_r && adv_ready;
  assign adv_valid   = pending_r || (in_ch.valid && !(in_frame && in_ch.flush));
  assign adv_fire    = adv_valid && adv_ready;
  assign adv_idx     = ic_r;

  // drop pixels that arrive after the frame is in
  assign adv_pix = (pending_r || !in_frame) ? '0 :
                   pixel_t'{red: in_ch.in_red, green: in_ch.in_green, blue: in_ch.in_blue};

  assign col_wrap = (32'(ic_r) + 1) >= 32'(w_r);
  assign produce  = (32'(ir_r) >= 2) || ((32'(ir_r) == 1) && (ic_r != '0));
  assign oc_end   = (32'(oc_r) + 1) >= 32'(w_r);
  assign or_end   = (32'(orow_r) + 1) >= 32'(h_r);

  always_comb begin
    adv_ctl.produce   = produce;
    adv_ctl.use_top   = (orow_r != '0);
    adv_ctl.use_bot   = !or_end;
    adv_ctl.use_left  = (oc_r != '0);
    adv_ctl.use_right = !oc_end;
    adv_ctl.last      = or_end && oc_end;
  end

  always_comb begin
    w_nxt       = w_r;
    h_nxt       = h_r;
    ic_nxt      = ic_r;
    ir_nxt      = ir_r;
    oc_nxt      = oc_r;
    orow_nxt    = orow_r;
    pending_nxt = pending_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_FRAME_WIDTH:  w_nxt = w_wr;
        CFG_FRAME_HEIGHT: h_nxt = h_wr;
        default: ;
      endcase
      ic_nxt      = '0;
      ir_nxt      = '0;
      oc_nxt      = '0;
      orow_nxt    = '0;
      pending_nxt = 1'b0;
    end else if (adv_fire) begin
      pending_nxt = !pending_r && !in_frame && !produce;
      if (col_wrap) begin
        ic_nxt = '0;
        ir_nxt = ir_r + IRW'(1);
      end else begin
        ic_nxt = ic_r + AW'(1);
      end
      if (produce) begin
        if (or_end && oc_end) begin
          ic_nxt   = '0;
          ir_nxt   = '0;
          oc_nxt   = '0;
          orow_nxt = '0;
        end else if (oc_end) begin
          oc_nxt   = '0;
          orow_nxt = orow_r + ORW'(1);
        end else begin
          oc_nxt = oc_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= WW'(RST_W);
      h_r       <= HW'(RST_H);
      ic_r      <= '0;
      ir_r      <= '0;
      oc_r      <= '0;
      orow_r    <= '0;
      pending_r <= 1'b0;
    end else begin
      w_r       <= w_nxt;
      h_r       <= h_nxt;
      ic_r      <= ic_nxt;
      ir_r      <= ir_nxt;
      oc_r      <= oc_nxt;
      orow_r    <= orow_nxt;
      pending_r <= pending_nxt;
    end
  end

  a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ic_r) < 32'(w_r))
    else $error("input column beyond frame width");

  a_out_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(oc_r) < 32'(w_r)) && (32'(orow_r) < 32'(h_r)))
    else $error("output position outside frame");

  a_pending_one_row: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> (32'(h_r) == 1))
    else $error("extra step pending on a frame taller than one row");

endmodule

`default_nettype wire

### rtl/core/bb3_window.sv
// ----------------------------------------------------------------------------
// bb3_window: line stores, 3x3 window and masked neighborhood sums
// Reads the two stored rows for each step, shifts the window, writes the
// rows back and registers per-channel sums with their neighbor count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bb3_window #(
  parameter int  MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF,
  localparam int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv_valid,
  output logic              adv_ready,
  input  logic [AW-1:0]     adv_idx,
  input  bb3_pkg::pixel_t   adv_pix,
  input  bb3_pkg::adv_ctl_t adv_ctl,
  output logic              sum_valid,
  input  logic              sum_ready,
  output bb3_pkg::sum_t     sum
);
  import bb3_pkg::*;

  row_pair_t line_mem [MAX_WIDTH];
  row_pair_t rd_mem_r;
  row_pair_t byp_data_r;
  logic      byp_r;

  logic      s1_v_r;
  logic [AW-1:0] s1_idx_r;
  pixel_t    s1_pix_r;
  adv_ctl_t  s1_ctl_r;

  pixel_t    win_a_r [3];
  pixel_t    win_b_r [3];
  pixel_t    newcol  [3];
  pixel_t    nb      [3][3];
  logic      row_use [3];
  logic      col_use [3];

  logic      s2_v_r;
  sum_t      s2_r, s2_nxt;

  row_pair_t rd;
  row_pair_t wdata;
  logic      s2_free;
  logic      s1_fire;
  logic      load;
  logic      bypass;
  logic [1:0] nrows, ncols;

  assign s2_free   = !s2_v_r || sum_ready;
  assign s1_fire   = s1_v_r && (!s1_ctl_r.produce || s2_free);
  assign adv_ready = !s1_v_r || s1_fire;
  assign load      = adv_valid && adv_ready;

  assign rd     = byp_r ? byp_data_r : rd_mem_r;
  assign wdata  = '{upper: rd.lower, lower: s1_pix_r};
  assign bypass = s1_fire && (s1_idx_r == adv_idx);

  assign newcol[0] = rd.upper;
  assign newcol[1] = rd.lower;
  assign newcol[2] = s1_pix_r;

  assign row_use[0] = s1_ctl_r.use_top;
  assign row_use[1] = 1'b1;
  assign row_use[2] = s1_ctl_r.use_bot;
  assign col_use[0] = s1_ctl_r.use_left;
  assign col_use[1] = 1'b1;
  assign col_use[2] = s1_ctl_r.use_right;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nb[r][0] = win_a_r[r];
      nb[r][1] = win_b_r[r];
      nb[r][2] = newcol[r];
    end
  end

  assign nrows = 2'(1) + 2'(s1_ctl_r.use_top) + 2'(s1_ctl_r.use_bot);
  assign ncols = 2'(1) + 2'(s1_ctl_r.use_left) + 2'(s1_ctl_r.use_right);

  always_comb begin
    s2_nxt.red   = '0;
    s2_nxt.green = '0;
    s2_nxt.blue  = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_use[r] && col_use[c]) begin
          s2_nxt.red   = s2_nxt.red   + SUM_W'(nb[r][c].red);
          s2_nxt.green = s2_nxt.green + SUM_W'(nb[r][c].green);
          s2_nxt.blue  = s2_nxt.blue  + SUM_W'(nb[r][c].blue);
        end
      end
    end
    s2_nxt.count = CNT_W'({2'b00, nrows}) * CNT_W'({2'b00, ncols});
    s2_nxt.last  = s1_ctl_r.last;
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      line_mem[s1_idx_r] <= wdata;
    end
    if (load) begin
      rd_mem_r <= line_mem[adv_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_idx_r   <= adv_idx;
      s1_pix_r   <= adv_pix;
      s1_ctl_r   <= adv_ctl;
      byp_r      <= bypass;
      byp_data_r <= wdata;
    end
    if (s1_fire) begin
      for (int r = 0; r < 3; r++) begin
        win_a_r[r] <= win_b_r[r];
        win_b_r[r] <= newcol[r];
      end
    end
    if (s1_fire && s1_ctl_r.produce) begin
      s2_r <= s2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (load) begin
        s1_v_r <= 1'b1;
      end else if (s1_fire) begin
        s1_v_r <= 1'b0;
      end
      if (s1_fire && s1_ctl_r.produce) begin
        s2_v_r <= 1'b1;
      end else if (sum_ready) begin
        s2_v_r <= 1'b0;
      end
    end
  end

  assign sum_valid = s2_v_r;
  assign sum       = s2_r;

endmodule

`default_nettype wire

### rtl/core/bb3_mean.sv
// ----------------------------------------------------------------------------
// bb3_mean: rounded mean and result register
// Divides each channel sum by its neighbor count with halves rounded up,
// using a reciprocal multiply, and holds the result word for the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bb3_mean (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          sum_valid,
  output logic          sum_ready,
  input  bb3_pkg::sum_t sum,
  bb3_out_if.source     out_ch
);
  import bb3_pkg::*;

  localparam int PROD_W = DIV_X_W + RECIP_W;

  logic            out_valid_r;
  logic [CH_W-1:0] red_r, green_r, blue_r;
  logic            last_r;
  logic [RECIP_W-1:0] m;

  // floor((2*s + n) / (2*n)) as (2*s + n) * m >> RECIP_SHIFT
  function automatic logic [CH_W-1:0] mean_ch(input logic [SUM_W-1:0] s,
                                              input logic [CNT_W-1:0] n,
                                              input logic [RECIP_W-1:0] mr);
    logic [DIV_X_W-1:0] x;
    logic [PROD_W-1:0]  p;
    x = DIV_X_W'({s, 1'b0}) + DIV_X_W'(n);
    p = PROD_W'(x) * PROD_W'(mr);
    return p[RECIP_SHIFT +: CH_W];
  endfunction

  assign m         = recip(sum.count);
  assign sum_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (sum_valid && sum_ready) begin
      red_r   <= mean_ch(sum.red,   sum.count, m);
      green_r <= mean_ch(sum.green, sum.count, m);
      blue_r  <= mean_ch(sum.blue,  sum.count, m);
      last_r  <= sum.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sum_ready) begin
      out_valid_r <= sum_valid;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_red   = red_r;
  assign out_ch.out_green = green_r;
  assign out_ch.out_blue  = blue_r;
  assign out_ch.last      = last_r;

  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    sum_valid |-> (sum.count == 4'd1 || sum.count == 4'd2 || sum.count == 4'd3 ||
                   sum.count == 4'd4 || sum.count == 4'd6 || sum.count == 4'd9))
    else $error("neighbor count not a legal window size");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sum_valid |-> ((32'(sum.red)   <= 255 * 32'(sum.count)) &&
                   (32'(sum.green) <= 255 * 32'(sum.count)) &&
                   (32'(sum.blue)  <= 255 * 32'(sum.count))))
    else $error("channel sum exceeds its neighbor count");

endmodule

`default_nettype wire

### rtl/core/box_blur_3x3_rgb.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb: 3x3 box filter on a raster stream of RGB pixels
// Pixels enter on in_ch in raster order; each leaves on out_ch as the
// rounded mean of its in-frame 3x3 neighbors (9, 6 or 4 of them; fewer on
// one-pixel-wide or one-row frames). A pixel's result becomes available once
// the word one row plus one pixel after it has been taken, so after the last
// pixel of a frame the source sends flush words, one per pending result, until
// out_ch.last marks the final pixel. Flush words before that point are taken
// and dropped; pixels sent after the frame is complete count as flushes.
// A completing word goes through the step, sum and result registers in turn.
// Throughput: one word per clock unless out_ch stalls, set by the single read
// and single write port of the row store; on a frame one row high the first
// flush adds a step that takes no word. Frame size is to be written on the
// cfg port only while the block is idle; the block does not enforce this. A
// write restarts the frame. Reset sets 640 x 480 and clears all positions; the
// row store is not cleared. When out_ch stalls, the result register holds and
// the pipeline keeps taking words until its three stages are full.
`timescale 1ns / 1ps
`default_nettype none

module box_blur_3x3_rgb #(
  parameter int  MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int  MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bb3_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data,
  bb3_in_if.sink                          in_ch,
  bb3_out_if.source                       out_ch
);
  import bb3_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic          adv_valid;
  logic          adv_ready;
  logic [AW-1:0] adv_idx;
  pixel_t        adv_pix;
  adv_ctl_t      adv_ctl;
  logic          sum_valid;
  logic          sum_ready;
  sum_t          sum;

  bb3_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .adv_valid (adv_valid),
    .adv_ready (adv_ready),
    .adv_idx   (adv_idx),
    .adv_pix   (adv_pix),
    .adv_ctl   (adv_ctl)
  );

  bb3_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv_valid (adv_valid),
    .adv_ready (adv_ready),
    .adv_idx   (adv_idx),
    .adv_pix   (adv_pix),
    .adv_ctl   (adv_ctl),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum)
  );

  bb3_mean u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

### tb/blur_checker.sv
// ----------------------------------------------------------------------------
// blur_checker: result predictor and scoreboard for box_blur_3x3_rgb
// Watches the configuration port and both pixel channels. Every word taken on
// the input channel runs through an in-testbench model of the line stores,
// the 3x3 window and the in-frame averaging. Any pixel it yields is queued,
// and each word taken on the result channel is compared field by field with
// the oldest queued pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blur_checker #(
  parameter int MAX_W = bb3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_H = bb3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bb3_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data,
  bb3_in_if                               in_mon,
  bb3_out_if                              out_mon,
  output int unsigned                     mismatches,
  output int unsigned                     pending,
  output int unsigned                     words_in,
  output int unsigned                     pixels_checked
);
  import bb3_pkg::*;

  typedef struct packed {
    pixel_t px;
    logic   last;
  } blurred_t;

  logic [FW_W-1:0] width_reg;
  logic [FH_W-1:0] height_reg;
  pixel_t          upper_row [MAX_W];
  pixel_t          lower_row [MAX_W];
  pixel_t          win [3][3];
  int unsigned     in_col, in_row, out_col, out_row;
  blurred_t        blurred_q [$];

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_H) return MAX_H;
    return height_reg;
  endfunction

  function automatic void restart_frame();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic logic [CH_W-1:0] rounded_mean(input int unsigned total,
                                                   input int unsigned n);
    return CH_W'((2 * total + n) / (2 * n));
  endfunction

  function automatic bit slide_window(input pixel_t pix, output blurred_t res);
    int unsigned w, h, col, base, oc, orow, n;
    int unsigned tot_r, tot_g, tot_b;
    int          r, c;
    pixel_t      prior [3][3];
    pixel_t      p;
    bit          produce;
    w       = active_width();
    h       = active_height();
    col     = in_col % MAX_W;
    produce = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    prior   = win;
    res     = '0;
    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2]      = upper_row[col];
    win[1][2]      = lower_row[col];
    win[2][2]      = pix;
    upper_row[col] = lower_row[col];
    lower_row[col] = pix;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!produce) return 1'b0;

    // a word in column 0 closes the previous row: use the window before shift
    base  = (col == 0) ? 2 : 1;
    oc    = out_col;
    orow  = out_row;
    n     = 0;
    tot_r = 0;
    tot_g = 0;
    tot_b = 0;
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) begin
        if ((r == 0 && orow == 0) || (r == 2 && orow + 1 >= h) ||
            (c == 0 && oc == 0) || (c == 2 && oc + 1 >= w)) continue;
        p = (col == 0) ? prior[r][base + c - 1] : win[r][base + c - 1];
        tot_r += p.red;
        tot_g += p.green;
        tot_b += p.blue;
        n++;
      end
    end
    res.px.red   = rounded_mean(tot_r, n);
    res.px.green = rounded_mean(tot_g, n);
    res.px.blue  = rounded_mean(tot_b, n);
    res.last     = (orow + 1 >= h) && (oc + 1 >= w);
    if (res.last) begin
      restart_frame();
    end else begin
      oc++;
      if (oc >= w) begin
        oc = 0;
        orow++;
      end
      out_col = oc;
      out_row = orow;
    end
    return 1'b1;
  endfunction

  function automatic bit blur_step(input logic flush, input pixel_t pix,
                                   output blurred_t res);
    res = '0;
    if (in_row < active_height()) begin
      if (flush) return 1'b0;
      return slide_window(pix, res);
    end
    // frame complete: drop the pixel, drain
    repeat (2) if (slide_window('0, res)) return 1'b1;
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input blurred_t want,
                                 input blurred_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
               $time, what, want.px.red, want.px.green, want.px.blue, want.last,
               got.px.red, got.px.green, got.px.blue, got.last);
  endtask

  always @(posedge clk) begin
    blurred_t want, got;
    if (!rst_n) begin
      width_reg  = FW_W'(FRAME_WIDTH_RST);
      height_reg = FH_W'(FRAME_HEIGHT_RST);
      foreach (win[r, c]) win[r][c] = '0;
      foreach (upper_row[i]) begin
        upper_row[i] = '0;
        lower_row[i] = '0;
      end
      restart_frame();
      blurred_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_FRAME_WIDTH:  width_reg = cfg_data[FW_W-1:0];
          CFG_FRAME_HEIGHT: height_reg = cfg_data[FH_W-1:0];
          default: ;
        endcase
        restart_frame();
      end
      if (in_mon.valid && in_mon.ready) begin
        words_in++;
        if (blur_step(in_mon.flush, {in_mon.in_red, in_mon.in_green, in_mon.in_blue},
                      want))
          blurred_q.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.out_red, out_mon.out_green, out_mon.out_blue, out_mon.last};
        if (blurred_q.size() == 0) begin
          report_mismatch("result word with none due", '0, got);
        end else begin
          want = blurred_q.pop_front();
          pixels_checked++;
          if (got.px.red !== want.px.red || got.px.green !== want.px.green ||
              got.px.blue !== want.px.blue || got.last !== want.last)
            report_mismatch("wrong result word", want, got);
        end
      end
    end
    pending = blurred_q.size();
  end

endmodule

### tb/tb_box_blur_3x3_rgb.sv
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_rgb: stimulus and verdict for the 3x3 RGB box blur
// Runs a partial frame at the reset size, a single-column frame at the reset
// height under a long output hold, short directed frames (corners, edges,
// clamped sizes, stray flushes, pixels past the frame end), then random frames
// with random idling on both channels, long output holds and aborted frames.
// Checking is in blur_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_box_blur_3x3_rgb;
  import bb3_pkg::*;

  localparam int unsigned WORD_TARGET   = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam pixel_t      WHITE         = '1;
  localparam pixel_t      BLACK         = '0;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int unsigned            mismatches, pending, words_in, pixels_checked;
  int unsigned            words_sent, holds_done;
  int unsigned            hold_request;
  bit                     calm;

  bb3_in_if  in_ch ();
  bb3_out_if out_ch ();

  box_blur_3x3_rgb uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  blur_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatches     (mismatches),
    .pending        (pending),
    .words_in       (words_in),
    .pixels_checked (pixels_checked)
  );

  always #5 clk = ~clk;

  initial begin
    #4_000_000;
    $display("timeout at %0t with %0d result words outstanding", $time, pending);
    $display("tb_box_blur_3x3_rgb failed");
    $finish;
  end

  // result side: random stalls, plus long holds on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
        holds_done++;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 18);
      end
    end
  end

  function automatic pixel_t rand_pixel();
    case ($urandom_range(9))
      0:       return WHITE;
      1:       return BLACK;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic fl, input pixel_t px);
    while (!calm && $urandom_range(99) < 18) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.flush    <= fl;
    in_ch.in_red   <= px.red;
    in_ch.in_green <= px.green;
    in_ch.in_blue  <= px.blue;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // w, h: frame size as the block sees it after clamping
  task automatic run_frame(input int unsigned w, input int unsigned h, input bit noisy);
    int unsigned tail;
    for (int unsigned i = 0; i < w * h; i++) begin
      if (noisy && $urandom_range(19) == 0) send_word(1'b1, rand_pixel());
      send_word(1'b0, rand_pixel());
    end
    tail = (h == 1) ? w : w + 1;
    repeat (tail) send_word((noisy && $urandom_range(3) == 0) ? 1'b0 : 1'b1, rand_pixel());
    if (noisy && $urandom_range(7) == 0) send_word(1'b1, rand_pixel());
  endtask

  initial begin
    int unsigned w, h, cut, frame_count;
    bit          restart;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_FRAME_WIDTH;
    cfg_data       <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.flush    <= 1'b0;
    in_ch.in_red   <= '0;
    in_ch.in_green <= '0;
    in_ch.in_blue  <= '0;
    calm         = 1'b0;
    hold_request = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size 640 x 480: a partial frame, then the reset height alone
    repeat (645) send_word(1'b0, rand_pixel());
    wait_drained();
    write_reg(CFG_FRAME_WIDTH, 1);
    hold_request = 300;
    run_frame(1, 480, 1'b0);
    wait_drained();

    // 3 x 3 checkerboard with a stray flush and a pixel past the end
    write_reg(CFG_FRAME_WIDTH, 3);
    write_reg(CFG_FRAME_HEIGHT, 3);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_word(1'b1, WHITE);
      send_word(1'b0, (i % 2 == 0) ? WHITE : BLACK);
    end
    send_word(1'b0, rand_pixel());
    repeat (3) send_word(1'b1, rand_pixel());
    wait_drained();

    // zero sizes clamp to one pixel
    write_reg(CFG_FRAME_WIDTH, 0);
    write_reg(CFG_FRAME_HEIGHT, 0);
    send_word(1'b1, WHITE);
    send_word(1'b0, WHITE);
    send_word(1'b1, BLACK);
    send_word(1'b1, BLACK);
    wait_drained();

    // upper data bit is not part of the width
    write_reg(CFG_FRAME_WIDTH, 13'h1002);
    run_frame(2, 1, 1'b0);
    wait_drained();

    // oversized height clamps to the largest frame; abort after a few rows
    write_reg(CFG_FRAME_WIDTH, 1);
    write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
    repeat (40) send_word(1'b0, rand_pixel());
    wait_drained();

    frame_count = 0;
    restart     = 1'b1;
    w           = 1;
    h           = 1;
    while (words_sent < WORD_TARGET) begin
      frame_count++;
      calm = (frame_count >= 10 && frame_count < 25);
      if (restart || $urandom_range(1) == 0) begin
        if ($urandom_range(9) == 0) begin
          w = $urandom_range(1, 48);
          h = $urandom_range(1, 3);
        end else begin
          w = $urandom_range(1, 10);
          h = $urandom_range(1, 6);
        end
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        restart = 1'b0;
      end else if ($urandom_range(7) == 0) begin
        wait_drained();
      end
      if ($urandom_range(14) == 0) hold_request = $urandom_range(100, 400);
      if (w * h > 1 && $urandom_range(11) == 0) begin
        // abort mid-frame; the next size write restarts it
        cut = $urandom_range(1, w * h - 1);
        repeat (cut) send_word(1'b0, rand_pixel());
        restart = 1'b1;
      end else begin
        run_frame(w, h, 1'b1);
      end
    end
    calm = 1'b0;
    wait_drained();

    $display("covered %0d input words: reset-size, clamped and single-column frames,",
             words_in);
    $display("then %0d random frames; checked %0d blurred pixels with %0d long output holds",
             frame_count, pixels_checked, holds_done);
    if (mismatches == 0 && pending == 0)
      $display("tb_box_blur_3x3_rgb passed");
    else
      $display("tb_box_blur_3x3_rgb failed");
    $finish;
  end

endmodule

### filelist.f
rtl/core/bb3_pkg.sv
rtl/core/bb3_if.sv
rtl/core/bb3_ctrl.sv
rtl/core/bb3_window.sv
rtl/core/bb3_mean.sv
rtl/core/box_blur_3x3_rgb.sv
tb/blur_checker.sv
tb/tb_box_blur_3x3_rgb.sv
